/* src/pipw_pkg.sv */
package pipw_pkg;

  localparam int COORD_BITS = 16;
  localparam int REL_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * REL_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int SUM_BITS   = 13;
  localparam int DELTA_BITS = 3;
  localparam int SUM_MAX    = 2048;
  localparam int SUM_MIN    = -2048;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [REL_BITS-1:0]   rel_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;

  localparam delta_t DELTA_NONE     = 3'sd0;
  localparam delta_t DELTA_HALF_UP  = 3'sd1;
  localparam delta_t DELTA_HALF_DN  = -3'sd1;
  localparam delta_t DELTA_FULL_UP  = 3'sd2;
  localparam delta_t DELTA_FULL_DN  = -3'sd2;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic  ys_neg;
    logic  ys_zero;
    logic  ye_neg;
    logic  ye_zero;
    logic  xs_pos;
    logic  xe_pos;
    prod_t p_se;
    prod_t p_es;
  } edge_prod_t;

  typedef struct packed {
    logic       first;
    logic       last;
    edge_prod_t e_prev;
    edge_prod_t e_close;
  } stage_t;

  function automatic sum_t sat_add(sum_t s, delta_t d);
    logic signed [SUM_BITS:0] t;
    t = {s[SUM_BITS-1], s} + {{(SUM_BITS + 1 - DELTA_BITS){d[DELTA_BITS-1]}}, d};
    if (t > (SUM_BITS + 1)'(SUM_MAX)) begin
      return sum_t'(SUM_MAX);
    end else if (t < (SUM_BITS + 1)'(SUM_MIN)) begin
      return sum_t'(SUM_MIN);
    end
    return t[SUM_BITS-1:0];
  endfunction

endpackage

/* src/pipw_edge_prod.sv */
module pipw_edge_prod
  import pipw_pkg::*;
(
  input  point_t     start_pt,
  input  point_t     end_pt,
  input  point_t     query_pt,
  output edge_prod_t prod
);

  rel_t xs;
  rel_t ys;
  rel_t xe;
  rel_t ye;

  assign xs = {start_pt.x[COORD_BITS-1], start_pt.x} - {query_pt.x[COORD_BITS-1], query_pt.x};
  assign ys = {start_pt.y[COORD_BITS-1], start_pt.y} - {query_pt.y[COORD_BITS-1], query_pt.y};
  assign xe = {end_pt.x[COORD_BITS-1], end_pt.x} - {query_pt.x[COORD_BITS-1], query_pt.x};
  assign ye = {end_pt.y[COORD_BITS-1], end_pt.y} - {query_pt.y[COORD_BITS-1], query_pt.y};

  always_comb begin
    prod.ys_neg  = ys[REL_BITS-1];
    prod.ys_zero = (ys == '0);
    prod.ye_neg  = ye[REL_BITS-1];
    prod.ye_zero = (ye == '0);
    prod.xs_pos  = !xs[REL_BITS-1] && (xs != '0);
    prod.xe_pos  = !xe[REL_BITS-1] && (xe != '0);
    prod.p_se    = ys * xe;
    prod.p_es    = xs * ye;
  end

endmodule

/* src/pipw_accum.sv */
module pipw_accum
  import pipw_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   s_valid,
  input  stage_t s,
  output logic   s_ready,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   inside_res,
  output sum_t   winding_halves
);

  sum_t               sum;
  sum_t               sum_next;
  sum_t               sum_mid;
  sum_t               base;
  delta_t             d_prev;
  delta_t             d_close;
  logic [SUM_BITS-1:0] mag;
  logic               go;

  function automatic delta_t edge_delta(edge_prod_t e);
    cross_t xprod;
    logic   ys_pos;
    logic   ye_pos;
    logic   opposite;
    logic   right;
    xprod   = e.p_se - e.p_es;
    ys_pos  = !e.ys_neg && !e.ys_zero;
    ye_pos  = !e.ye_neg && !e.ye_zero;
    opposite = (e.ys_neg && ye_pos) || (ys_pos && e.ye_neg);
    right   = ys_pos ? (!xprod[CROSS_BITS-1] && (xprod != '0)) : xprod[CROSS_BITS-1];
    priority if (opposite) begin
      return right ? (e.ys_neg ? DELTA_FULL_UP : DELTA_FULL_DN) : DELTA_NONE;
    end else if (e.ys_zero && e.xs_pos) begin
      return e.ye_zero ? DELTA_NONE : (ye_pos ? DELTA_HALF_UP : DELTA_HALF_DN);
    end else if (e.ye_zero && e.xe_pos) begin
      return e.ys_zero ? DELTA_NONE : (e.ys_neg ? DELTA_HALF_UP : DELTA_HALF_DN);
    end else begin
      return DELTA_NONE;
    end
  endfunction

  always_comb begin
    base     = s.first ? '0 : sum;
    d_prev   = s.first ? DELTA_NONE : edge_delta(s.e_prev);
    sum_mid  = sat_add(base, d_prev);
    d_close  = s.last ? edge_delta(s.e_close) : DELTA_NONE;
    sum_next = sat_add(sum_mid, d_close);
    mag      = sum_next[SUM_BITS-1] ? SUM_BITS'(-sum_next) : sum_next;
  end

  assign go      = s_valid && (!s.last || !out_valid || out_ready);
  assign s_ready = !s_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        sum <= sum_next;
      end
      priority if (go && s.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && s.last) begin
      winding_halves <= sum_next;
      inside_res     <= mag[1];
    end
  end

endmodule

/* src/point_in_polygon_winding.sv */
// Winding-number point-in-polygon test over a stream of vertices.
// Input channel (in_valid/in_ready): one polygon vertex per request, with
// first_vertex marking the start of a polygon (query_x/query_y are taken
// only there) and last_vertex closing it. A vertex may be both first and last.
// Output channel (out_valid/out_ready): one result per polygon, sent after
// its last vertex: winding_halves is the winding sum in half units,
// saturated to -2048..2048, and inside_res is bit 1 of its magnitude.
// Throughput: one vertex per cycle, sustained while the receiver takes results.
// After the last vertex is accepted, its result passes through the input
// register and the product stage and is then accumulated into the result
// register.
// Reset clears all pipeline valids, the query, first and previous points and
// the winding sum; vertices sent before any first vertex use these zeros.
// When the receiver stalls, the result register holds and vertices that
// produce no result keep flowing; in_ready drops only once the input
// register, the product stage and the result register are all occupied.
module point_in_polygon_winding
  import pipw_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t query_x,
  input  coord_t query_y,
  input  coord_t vert_x,
  input  coord_t vert_y,
  input  logic   first_vertex,
  input  logic   last_vertex,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   inside_res,
  output sum_t   winding_halves
);

  logic       s0_valid;
  point_t     s0_query;
  point_t     s0_vert;
  logic       s0_first;
  logic       s0_last;
  logic       s0_go;
  logic       s1_valid;
  logic       s1_ready;
  stage_t     s1;
  stage_t     s1_next;
  point_t     query_pt;
  point_t     first_pt;
  point_t     prev_pt;
  point_t     close_query;
  point_t     close_first;
  edge_prod_t prod_prev;
  edge_prod_t prod_close;
  logic [SUM_BITS-1:0] out_mag;

  assign in_ready    = !s0_valid || s1_ready;
  assign s0_go       = s0_valid && s1_ready;
  assign close_query = s0_first ? s0_query : query_pt;
  assign close_first = s0_first ? s0_vert : first_pt;

  pipw_edge_prod u_prev (
    .start_pt (prev_pt),
    .end_pt   (s0_vert),
    .query_pt (query_pt),
    .prod     (prod_prev)
  );

  pipw_edge_prod u_close (
    .start_pt (s0_vert),
    .end_pt   (close_first),
    .query_pt (close_query),
    .prod     (prod_close)
  );

  always_comb begin
    s1_next.first   = s0_first;
    s1_next.last    = s0_last;
    s1_next.e_prev  = prod_prev;
    s1_next.e_close = prod_close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      query_pt <= '0;
      first_pt <= '0;
      prev_pt  <= '0;
    end else begin
      if (in_ready) begin
        s0_valid <= in_valid;
      end
      if (s1_ready) begin
        s1_valid <= s0_valid;
      end
      if (s0_go) begin
        prev_pt <= s0_vert;
        if (s0_first) begin
          query_pt <= s0_query;
          first_pt <= s0_vert;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_query <= '{x: query_x, y: query_y};
      s0_vert  <= '{x: vert_x, y: vert_y};
      s0_first <= first_vertex;
      s0_last  <= last_vertex;
    end
    if (s0_go) begin
      s1 <= s1_next;
    end
  end

  pipw_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .s_valid        (s1_valid),
    .s              (s1),
    .s_ready        (s1_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .inside_res     (inside_res),
    .winding_halves (winding_halves)
  );

  assign out_mag = winding_halves[SUM_BITS-1] ? SUM_BITS'(-winding_halves) : winding_halves;

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (winding_halves >= sum_t'(SUM_MIN)) && (winding_halves <= sum_t'(SUM_MAX)))
    else $error("winding sum out of saturation range");

  a_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inside_res == out_mag[1]))
    else $error("inside flag disagrees with winding sum");

  a_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s0_valid && s1_valid && out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1.last))
    else $error("result without a closing vertex");

endmodule

/* tb/tb_point_in_polygon_winding.sv */
`timescale 1ns / 100ps

module tb_point_in_polygon_winding;
  import pipw_pkg::*;

  localparam int PIPE_LATENCY = 3;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int SPIRAL_LOOPS = 250;
  localparam int N_DIRECTED   = 24;

  typedef struct packed {
    coord_t qx;
    coord_t qy;
    coord_t vx;
    coord_t vy;
    logic   first;
    logic   last;
  } vertex_t;

  typedef struct packed {
    logic odd;
    sum_t halves;
  } verdict_t;

  typedef struct packed {
    vertex_t  v;
    logic     typed;
    verdict_t want;
  } dir_row_t;

  logic   clk;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t query_x = '0;
  coord_t query_y = '0;
  coord_t vert_x = '0;
  coord_t vert_y = '0;
  logic   first_vertex = 1'b0;
  logic   last_vertex = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   inside_res;
  sum_t   winding_halves;

  point_in_polygon_winding dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .query_x        (query_x),
    .query_y        (query_y),
    .vert_x         (vert_x),
    .vert_y         (vert_y),
    .first_vertex   (first_vertex),
    .last_vertex    (last_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .inside_res     (inside_res),
    .winding_halves (winding_halves)
  );

  // query, first and previous point, winding sum in half units
  int q_x, q_y, f_x, f_y, p_x, p_y, wsum;

  verdict_t pending_verdicts[$];
  verdict_t head;
  bit       calm = 1'b0;
  int       cycles = 0;
  int       n_sent = 0;
  int       n_rand = 0;
  int       n_checked = 0;
  int       n_errors = 0;
  int       sat_hi = 0;
  int       sat_lo = 0;

  dir_row_t directed_tab [N_DIRECTED] = '{
    '{'{16'sd0, 16'sd0, 16'sd5, -16'sd5, 1'b0, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd0, 16'sd0, -16'sd3, 16'sd7, 1'b0, 1'b1}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1, 1'b1}, 1'b1, '{1'b0, 13'sd0}},
    '{'{16'sd100, -16'sd200, 16'sd90, -16'sd210, 1'b1, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd100, -16'sd200, 16'sd110, -16'sd210, 1'b0, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd100, -16'sd200, 16'sd110, -16'sd190, 1'b0, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd100, -16'sd200, 16'sd90, -16'sd190, 1'b0, 1'b1}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd100, -16'sd200, 16'sd90, -16'sd210, 1'b1, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd100, -16'sd200, 16'sd90, -16'sd190, 1'b0, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd100, -16'sd200, 16'sd110, -16'sd190, 1'b0, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd100, -16'sd200, 16'sd110, -16'sd210, 1'b0, 1'b1}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd5, 16'sd0, 1'b1, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd5, 1'b0, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd0, 16'sd0, -16'sd5, -16'sd5, 1'b0, 1'b1}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sh8000, 16'sd0, 16'sh7fff, 16'sh8000, 1'b1, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sh8000, 16'sd0, 16'sh7fff, 16'sh7fff, 1'b0, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sh8000, 16'sd0, 16'sh8000, 16'sh7fff, 1'b0, 1'b1}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd0, 16'sd0, -16'sd5, -16'sd5, 1'b1, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd5, 16'sd5, 1'b0, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd5, -16'sd8, 1'b0, 1'b1}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd3, 16'sd0, 1'b1, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd9, 16'sd0, 1'b0, 1'b0}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sd0, 16'sd0, 16'sd6, 16'sd4, 1'b0, 1'b1}, 1'b0, '{1'b0, 13'sd0}},
    '{'{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b1, 1'b1}, 1'b1, '{1'b0, 13'sd0}}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run stalled, %0d results still owed", $time, pending_verdicts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 14);
  end

  function automatic int edge_gain(int sx, int sy, int ex, int ey);
    longint xs, ys, xe, ye, cr;
    xs = sx - q_x;
    ys = sy - q_y;
    xe = ex - q_x;
    ye = ey - q_y;
    if ((ys < 0 && ye > 0) || (ys > 0 && ye < 0)) begin
      cr = ys * xe - xs * ye;
      if ((ys > 0) ? (cr > 0) : (cr < 0)) return (ys < 0) ? 2 : -2;
      return 0;
    end
    if (ys == 0 && xs > 0) return (ye == 0) ? 0 : ((ye > 0) ? 1 : -1);
    if (ye == 0 && xe > 0 && ys != 0) return (ys < 0) ? 1 : -1;
    return 0;
  endfunction

  function automatic void add_gain(int g);
    wsum = wsum + g;
    if (wsum > SUM_MAX) wsum = SUM_MAX;
    if (wsum < SUM_MIN) wsum = SUM_MIN;
  endfunction

  function automatic bit fold_vertex(vertex_t v, output verdict_t r);
    int cx, cy, mag;
    cx = int'(v.vx);
    cy = int'(v.vy);
    r = '0;
    if (v.first) begin
      q_x = int'(v.qx);
      q_y = int'(v.qy);
      f_x = cx;
      f_y = cy;
      wsum = 0;
    end else begin
      add_gain(edge_gain(p_x, p_y, cx, cy));
    end
    p_x = cx;
    p_y = cy;
    if (!v.last) return 1'b0;
    add_gain(edge_gain(cx, cy, f_x, f_y));
    mag = (wsum < 0) ? -wsum : wsum;
    r.odd = ((mag / 2) % 2) != 0;
    r.halves = sum_t'(wsum);
    return 1'b1;
  endfunction

  function automatic coord_t near(coord_t c, int span);
    int t;
    t = int'(c) - span + int'($urandom_range(0, 2 * span));
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return coord_t'(t);
  endfunction

  task automatic push_vertex(input vertex_t v, input bit typed, input verdict_t want);
    verdict_t r;
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    query_x      <= v.qx;
    query_y      <= v.qy;
    vert_x       <= v.vx;
    vert_y       <= v.vy;
    first_vertex <= v.first;
    last_vertex  <= v.last;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (fold_vertex(v, r)) pending_verdicts.push_back(typed ? want : r);
  endtask

  task automatic settle_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic random_polygon();
    int n, span, twist;
    coord_t qx, qy;
    vertex_t v;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
    case ($urandom_range(0, 3))
      0: span = 0;
      1: span = 3;
      2: span = 40;
      default: span = 2000;
    endcase
    twist = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    qx = coord_t'($urandom);
    qy = coord_t'($urandom);
    for (int i = 0; i < n; i++) begin
      v.qx = (i == 0) ? qx : coord_t'($urandom);
      v.qy = (i == 0) ? qy : coord_t'($urandom);
      v.vx = (span == 0) ? coord_t'($urandom) : near(qx, span);
      v.vy = (span == 0) ? coord_t'($urandom) : near(qy, span);
      v.first = (i == 0);
      v.last = (i == n - 1);
      case (twist)
        1: v.first = 1'b0;
        2: v.last = 1'b0;
        3: begin
          v.first = ($urandom_range(0, 3) == 0);
          v.last = ($urandom_range(0, 3) == 0);
        end
        default: ;
      endcase
      push_vertex(v, 1'b0, '0);
      n_rand++;
    end
  endtask

  // zigzag around the query, each loop adds one full turn; ends on a left
  // vertex so the closing edge adds nothing and the sum shows as is
  task automatic spiral(int turn);
    int qx, qy;
    vertex_t v;
    qx = int'($urandom_range(0, 40000)) - 20000;
    qy = int'($urandom_range(0, 40000)) - 20000;
    v.qx = coord_t'(qx);
    v.qy = coord_t'(qy);
    for (int j = 0; j <= SPIRAL_LOOPS; j++) begin
      v.vx = coord_t'(qx - (2 * j + 1));
      v.vy = coord_t'(qy - turn);
      v.first = (j == 0);
      v.last = (j == SPIRAL_LOOPS);
      push_vertex(v, 1'b0, '0);
      if (j < SPIRAL_LOOPS) begin
        v.vx = coord_t'(qx + 2 * j + 2);
        v.vy = coord_t'(qy + turn);
        v.first = 1'b0;
        v.last = 1'b0;
        push_vertex(v, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result inside_res=%0b winding_halves=%0d",
                 $time, inside_res, winding_halves);
        n_errors++;
      end else begin
        head = pending_verdicts.pop_front();
        n_checked++;
        if (head.halves == sum_t'(SUM_MAX)) sat_hi++;
        if (head.halves == sum_t'(SUM_MIN)) sat_lo++;
        if (inside_res !== head.odd) begin
          $display("%0t: inside_res expected %0b got %0b", $time, head.odd, inside_res);
          n_errors++;
        end
        if (winding_halves !== head.halves) begin
          $display("%0t: winding_halves expected %0d got %0d",
                   $time, head.halves, winding_halves);
          n_errors++;
        end
      end
    end
  end

  initial begin
    q_x = 0;
    q_y = 0;
    f_x = 0;
    f_y = 0;
    p_x = 0;
    p_y = 0;
    wsum = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_tab[k]) begin
      push_vertex(directed_tab[k].v, directed_tab[k].typed, directed_tab[k].want);
    end
    // hold the sender until every result is back
    settle_results();

    while (n_rand < 200) random_polygon();
    calm = 1'b1;
    spiral(1);
    while (n_rand < 350) random_polygon();
    calm = 1'b0;
    settle_results();
    spiral(-1);
    while (n_rand < 525) random_polygon();

    settle_results();
    $display("%0d vertex requests sent (%0d random), %0d polygon results checked",
             n_sent, n_rand, n_checked);
    $display("winding sum clamped at the top %0d and bottom %0d times", sat_hi, sat_lo);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
